>>> rtl/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude core.
// Used by the line buffer, the gradient kernel and the top level.
// No dependencies.
package sem_pkg;

    localparam int PIX_W = 8;
    localparam int CH_N  = 3;

    // Channel order inside a packed pixel: blue in the low byte.
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int LW_REG_W   = 12;
    localparam int FH_REG_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int LW_RESET = 640;
    localparam int FH_RESET = 480;
    localparam int DIM_MIN  = 3;

    // Rows and columns before this index have no full neighborhood.
    localparam int BORDER = 2;

    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    typedef logic [CH_N-1:0][PIX_W-1:0] pixel_t;

    // One column of the 3x3 neighborhood.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } col_t;

    typedef struct packed {
        col_t left;
        col_t center;
        col_t right;
    } win_t;

    typedef struct packed {
        logic eor;
        logic eof;
    } ctl_t;

endpackage

>>> rtl/sem_line_buf.sv
// Position counters, the two-row line memory with write-back forwarding, and
// the 3x3 window register. Hands interior windows to the gradient kernel.
// Depends on sem_pkg.
module sem_line_buf
    import sem_pkg::*;
#(
    parameter int MAX_LINE_WIDTH   = 2048,
    parameter int MAX_FRAME_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_LINE_WIDTH),
    localparam int ROW_W = $clog2(MAX_FRAME_HEIGHT),
    localparam int WW    = $clog2(MAX_LINE_WIDTH + 1),
    localparam int HW    = $clog2(MAX_FRAME_HEIGHT + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [WW-1:0] width_i,
    input  logic [HW-1:0] height_i,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_sof,
    input  pixel_t        s_pix,
    output logic          valid_o,
    input  logic          ready_i,
    output win_t          win_o,
    output ctl_t          ctl_o
);

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    line_word_t line_mem [MAX_LINE_WIDTH];

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [WW-1:0]    col_x, col_inc;
    logic [HW-1:0]    row_x, row_inc;
    logic             wrap_col;
    logic             acc;
    logic             res_now;
    ctl_t             ctl_now;

    // Stage 1: memory read in flight.
    logic             v1_reg, v1_next;
    logic [COL_W-1:0] a1_reg;
    pixel_t           cur1_reg;
    logic             res1_reg;
    ctl_t             ctl1_reg;
    line_word_t       rd_reg;
    logic             fwd_hit_reg;
    line_word_t       fwd_word_reg;
    line_word_t       eff_word;
    logic             adv1;

    col_t             win_left_reg, win_center_reg, col_now;

    // Stage 2: a full interior window.
    logic             v2_reg, v2_next;
    win_t             win2_reg;
    ctl_t             ctl2_reg;

    assign acc = s_valid && s_ready;

    // Position of the incoming pixel; a frame start restarts both counters.
    always_comb begin
        col_cur  = s_sof ? '0 : col_reg;
        row_cur  = s_sof ? '0 : row_reg;
        col_x    = WW'(col_cur);
        row_x    = HW'(row_cur);
        col_inc  = col_x + 1'b1;
        row_inc  = row_x + 1'b1;
        wrap_col = (col_inc >= width_i);
        col_next = wrap_col ? '0 : col_inc[COL_W-1:0];
        if (!wrap_col) begin
            row_next = row_cur;
        end else if (row_inc >= height_i) begin
            row_next = '0;
        end else begin
            row_next = row_inc[ROW_W-1:0];
        end
        res_now = (row_x >= HW'(BORDER)) && (col_x >= WW'(BORDER))
                  && (col_x < width_i) && (row_x < height_i);
        ctl_now.eor = (col_x == width_i - 1'b1);
        ctl_now.eof = ctl_now.eor && (row_x == height_i - 1'b1);
    end

    // A pixel without a result leaves stage 1 freely; one with a result
    // needs room in stage 2.
    assign adv1    = v1_reg && (!res1_reg || !v2_reg || ready_i);
    assign s_ready = !v1_reg || adv1;

    // The previous pixel writes its entry on the same edge that the next one
    // reads; a read of that same entry takes the written word from here.
    assign eff_word = fwd_hit_reg ? fwd_word_reg : rd_reg;

    always_comb begin
        col_now.top = eff_word.upper;
        col_now.mid = eff_word.middle;
        col_now.bot = cur1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            line_mem[a1_reg] <= '{upper: eff_word.middle, middle: cur1_reg};
        end
        if (acc) begin
            rd_reg <= line_mem[col_cur];
        end
    end

    assign v1_next = acc || (v1_reg && !adv1);
    assign v2_next = (adv1 && res1_reg) || (v2_reg && !ready_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            win_left_reg   <= '0;
            win_center_reg <= '0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (acc) begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                fwd_hit_reg <= adv1 && (a1_reg == col_cur);
            end
            if (adv1) begin
                win_left_reg   <= win_center_reg;
                win_center_reg <= col_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            a1_reg       <= col_cur;
            cur1_reg     <= s_pix;
            res1_reg     <= res_now;
            ctl1_reg     <= ctl_now;
            fwd_word_reg <= '{upper: eff_word.middle, middle: cur1_reg};
        end
        if (adv1 && res1_reg) begin
            win2_reg.left   <= win_left_reg;
            win2_reg.center <= win_center_reg;
            win2_reg.right  <= col_now;
            ctl2_reg        <= ctl1_reg;
        end
    end

    assign valid_o = v2_reg;
    assign win_o   = win2_reg;
    assign ctl_o   = ctl2_reg;

`ifndef SYNTHESIS
    a_acc_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> v1_reg)
        else $error("accepted request did not reach stage 1");
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && res1_reg && v2_reg && !ready_i))
        else $error("input stalled without a full pipeline");
    a_result_to_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && res1_reg) |=> v2_reg)
        else $error("interior window lost between stages");
`endif

endmodule

>>> rtl/sem_kernel.sv
// Sobel gradient pair and saturated L1 magnitude for the three channels,
// followed by the result register. Depends on sem_pkg.
module sem_kernel
    import sem_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             valid_i,
    output logic             ready_o,
    input  win_t             win_i,
    input  ctl_t             ctl_i,
    output logic             m_valid,
    input  logic             m_ready,
    output pixel_t           m_edge,
    output ctl_t             m_ctl
);

    // Taps a[r*3+c], row 0 on top, column 0 on the left.
    function automatic logic [PIX_W-1:0] sobel_mag(input logic [8:0][PIX_W-1:0] a);
        logic [PIX_W+1:0]        pos1, neg1, pos2, neg2;
        logic signed [PIX_W+2:0] d1, d2;
        logic [PIX_W+1:0]        m1, m2;
        logic [PIX_W+2:0]        s;
        pos1 = {2'b00, a[6]} + {1'b0, a[7], 1'b0} + {2'b00, a[8]};
        neg1 = {2'b00, a[0]} + {1'b0, a[1], 1'b0} + {2'b00, a[2]};
        pos2 = {2'b00, a[2]} + {1'b0, a[5], 1'b0} + {2'b00, a[8]};
        neg2 = {2'b00, a[0]} + {1'b0, a[3], 1'b0} + {2'b00, a[6]};
        d1   = $signed({1'b0, pos1}) - $signed({1'b0, neg1});
        d2   = $signed({1'b0, pos2}) - $signed({1'b0, neg2});
        m1   = d1[PIX_W+2] ? (PIX_W+2)'(-d1) : d1[PIX_W+1:0];
        m2   = d2[PIX_W+2] ? (PIX_W+2)'(-d2) : d2[PIX_W+1:0];
        s    = {1'b0, m1} + {1'b0, m2};
        return (s > (PIX_W+3)'(EDGE_MAX)) ? EDGE_MAX : s[PIX_W-1:0];
    endfunction

    logic   m_valid_reg, m_valid_next;
    pixel_t edge_reg;
    ctl_t   ctl_reg;
    pixel_t mag;
    logic   load;

    always_comb begin
        logic [8:0][PIX_W-1:0] nb;
        nb = '0;
        for (int ch = 0; ch < CH_N; ch++) begin
            nb = {win_i.right.bot[ch], win_i.center.bot[ch], win_i.left.bot[ch],
                  win_i.right.mid[ch], win_i.center.mid[ch], win_i.left.mid[ch],
                  win_i.right.top[ch], win_i.center.top[ch], win_i.left.top[ch]};
            mag[ch] = sobel_mag(nb);
        end
    end

    assign ready_o      = !m_valid_reg || m_ready;
    assign load         = valid_i && ready_o;
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            edge_reg <= mag;
            ctl_reg  <= ctl_i;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_edge  = edge_reg;
    assign m_ctl   = ctl_reg;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

>>> rtl/sobel_edge_magnitude_rgb_core.sv
// Streaming 3x3 Sobel edge magnitude core for RGB pixels, top level.
// Holds the configuration registers and joins line buffer and kernel.
// Depends on sem_pkg, sem_line_buf and sem_kernel.
//
// Pixels enter in raster order on the s_ channel, one request per pixel;
// s_start_of_frame marks the first pixel of a frame. For each interior pixel
// the m_ channel delivers the saturated |Gx|+|Gy| of blue, green and red for
// the pixel one row above and one column left of the one just taken, with
// end-of-row and end-of-frame flags. Border pixels give no result.
// The request that completes a window is held in stage 1, its window in stage 2
// and its result in the kernel's result register.
// Throughput is one pixel per clock while m_ready does not stall the output, set by
// the line memory, which is read and written once per pixel at the column address.
// Write line_width and frame_height through cfg_we/cfg_index/cfg_wdata while
// the core is idle; values are clamped to 3..MAX on write.
// Reset clears the position counters, the window and the pipeline; the line
// memory is not cleared and needs no clearing pass. While m_ready is low with
// a result waiting, two more interior pixels are taken, along with any border
// pixels in between, before s_ready falls.
module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
#(
    parameter int MAX_LINE_WIDTH   = 2048,
    parameter int MAX_FRAME_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_start_of_frame,
    input  logic [PIX_W-1:0]      s_blue_in,
    input  logic [PIX_W-1:0]      s_green_in,
    input  logic [PIX_W-1:0]      s_red_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_blue_edge,
    output logic [PIX_W-1:0]      m_green_edge,
    output logic [PIX_W-1:0]      m_red_edge,
    output logic                  m_end_of_row,
    output logic                  m_end_of_frame
);

    localparam int WW     = $clog2(MAX_LINE_WIDTH + 1);
    localparam int HW     = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int LW_CW  = (LW_REG_W > WW) ? LW_REG_W : WW;
    localparam int FH_CW  = (FH_REG_W > HW) ? FH_REG_W : HW;
    localparam int W_RST  = (LW_RESET > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : LW_RESET;
    localparam int H_RST  = (FH_RESET > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : FH_RESET;

    logic [WW-1:0]    width_reg, width_next;
    logic [HW-1:0]    height_reg, height_next;
    logic [LW_CW-1:0] lw_raw;
    logic [FH_CW-1:0] fh_raw;

    pixel_t s_pix;
    logic   k_valid, k_ready;
    win_t   k_win;
    ctl_t   k_ctl;
    pixel_t m_edge;
    ctl_t   m_ctl;

    always_comb begin
        lw_raw = LW_CW'(cfg_wdata[LW_REG_W-1:0]);
        fh_raw = FH_CW'(cfg_wdata[FH_REG_W-1:0]);
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH: begin
                    if (lw_raw < LW_CW'(DIM_MIN)) begin
                        width_next = WW'(DIM_MIN);
                    end else if (lw_raw > LW_CW'(MAX_LINE_WIDTH)) begin
                        width_next = WW'(MAX_LINE_WIDTH);
                    end else begin
                        width_next = lw_raw[WW-1:0];
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (fh_raw < FH_CW'(DIM_MIN)) begin
                        height_next = HW'(DIM_MIN);
                    end else if (fh_raw > FH_CW'(MAX_FRAME_HEIGHT)) begin
                        height_next = HW'(MAX_FRAME_HEIGHT);
                    end else begin
                        height_next = fh_raw[HW-1:0];
                    end
                end
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb begin
        s_pix[CH_BLUE]  = s_blue_in;
        s_pix[CH_GREEN] = s_green_in;
        s_pix[CH_RED]   = s_red_in;
    end

    sem_line_buf #(
        .MAX_LINE_WIDTH  (MAX_LINE_WIDTH),
        .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .width_i (width_reg),
        .height_i(height_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_sof   (s_start_of_frame),
        .s_pix   (s_pix),
        .valid_o (k_valid),
        .ready_i (k_ready),
        .win_o   (k_win),
        .ctl_o   (k_ctl)
    );

    sem_kernel u_kernel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (k_valid),
        .ready_o (k_ready),
        .win_i   (k_win),
        .ctl_i   (k_ctl),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_edge  (m_edge),
        .m_ctl   (m_ctl)
    );

    assign m_blue_edge    = m_edge[CH_BLUE];
    assign m_green_edge   = m_edge[CH_GREEN];
    assign m_red_edge     = m_edge[CH_RED];
    assign m_end_of_row   = m_ctl.eor;
    assign m_end_of_frame = m_ctl.eof;

endmodule
